@@ hdl/tccw_pkg.sv @@
// Shared constants and action codes for the text console cell writer.
`default_nettype none

package tccw_pkg;

  localparam int POS_W    = 11;
  localparam int ACTION_W = 3;
  localparam int CHAR_W   = 8;
  localparam int ATTR_W   = 8;
  localparam int CELL_W   = 16;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SET   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_READ  = 3'd4;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
  localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

endpackage

`default_nettype wire

@@ hdl/tccw_screen_mem.sv @@
// Screen cell store: one write port, one registered read port.
`default_nettype none

module tccw_screen_mem
  import tccw_pkg::*;
#(
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [CELL_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic      [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= cells[raddr];
  end

endmodule

`default_nettype wire

@@ hdl/tccw_pos_split.sv @@
// Iterative split of a cell index into row and column by repeated subtraction.
`default_nettype none

module tccw_pos_split
  import tccw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS,
  parameter int AW      = $clog2(COLUMNS * ROWS),
  parameter int RW      = $clog2(ROWS),
  parameter int CLW     = $clog2(COLUMNS)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           go,
  input  wire logic [AW-1:0]  value,
  output logic                done,
  output logic      [RW-1:0]  row,
  output logic      [CLW-1:0] col
);

  localparam int CNW = $clog2(COLUMNS + 1);
  localparam int EW  = (AW > CNW) ? AW : CNW;

  logic          running;
  logic [EW-1:0] rem;
  logic [RW-1:0] row_cnt;

  assign done = running && (rem < EW'(COLUMNS));
  assign row  = row_cnt;
  assign col  = rem[CLW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (go) begin
      running <= 1'b1;
      rem     <= EW'(value);
      row_cnt <= '0;
    end else if (running) begin
      if (done) begin
        running <= 1'b0;
      end else begin
        rem     <= rem - EW'(COLUMNS);
        row_cnt <= row_cnt + RW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ hdl/text_console_cell_writer.sv @@
// Top level of the text console cell writer: sequencer, cursor and result register.
`default_nettype none

// Text console engine holding a ROWS x COLUMNS screen of 16-bit cells
// (attribute high byte, character low byte) plus a cursor.
// Command channel: a transaction is taken at a rising edge with start high
// and busy low. Result channel: done pulses for one cycle with cursor_index
// and cell_word; the receiver cannot hold a result off.
// Path from the accepting edge to done, per action:
//   write char, backspace, undefined action, out-of-range read: done is set
//     at accept; the next may start in the cycle after (1 per cycle).
//   read in range: through S_READ, which takes the registered store read.
//   set cursor: through S_SPLIT, one subtraction of COLUMNS per row.
//   clear: through S_FILL, one cell written per cycle.
//   newline or wrap on the last row (scroll): through S_SCROLL and S_FLUSH;
//     each cell below the top row is copied up one row through the single
//     read port, then the bottom row is blanked in S_FILL.
// Reset: the cursor goes home and a clearing pass writes blank gray cells
// (0x0720) to the whole store; busy is high meanwhile and no result
// is produced for it.
module text_console_cell_writer
  import tccw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [ACTION_W-1:0] action,
  input  wire logic [CHAR_W-1:0]   char_code,
  input  wire logic [ATTR_W-1:0]   attribute,
  input  wire logic [POS_W-1:0]    position,
  output logic                     done,
  output logic      [POS_W-1:0]    cursor_index,
  output logic      [CELL_W-1:0]   cell_word
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int AW   = $clog2(CELL_COUNT);
  localparam int RW   = $clog2(ROWS);
  localparam int CLW  = $clog2(COLUMNS);
  localparam int IW   = (AW > POS_W) ? AW : POS_W;
  localparam int CMPW = ((AW + 1) > POS_W) ? (AW + 1) : POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_SPLIT  = 3'd2;
  localparam logic [2:0] S_SCROLL = 3'd3;
  localparam logic [2:0] S_FLUSH  = 3'd4;
  localparam logic [2:0] S_FILL   = 3'd5;

  logic [2:0]        state;
  logic [RW-1:0]     row;
  logic [CLW-1:0]    col;
  logic [AW-1:0]     ptr;          // sweep pointer for scroll and fill
  logic [AW-1:0]     copy_dst;     // destination of the copy in flight
  logic              copy_pending; // read data this cycle goes to copy_dst
  logic [CELL_W-1:0] fill_cell;
  logic              fill_report;  // fill ends a transaction (not the reset pass)
  logic              split_go;

  logic              accept;
  logic [AW-1:0]     cur_addr;
  logic [AW-1:0]     bs_addr;
  logic [IW-1:0]     cur_ext;
  logic [CMPW-1:0]   pos_ext;
  logic              pos_in_range;
  logic [AW-1:0]     pos_addr;
  logic [AW-1:0]     pos_clamped;
  logic              row_last;
  logic              col_last;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  logic              split_done;
  logic [RW-1:0]     split_row;
  logic [CLW-1:0]    split_col;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // The splitter takes the position at the accepting edge itself.
  assign split_go = accept && action == ACT_SET;

  // Cursor cell address; row and column always stay in range.
  assign cur_addr = AW'(row) * AW'(COLUMNS) + AW'(col);
  // Backspace target: one cell back, which also covers the step to the
  // last column of the row above; home stays home.
  assign bs_addr  = (cur_addr == '0) ? '0 : cur_addr - AW'(1);
  assign cur_ext      = IW'(cur_addr);
  assign cursor_index = cur_ext[POS_W-1:0];

  assign pos_ext      = CMPW'(position);
  assign pos_in_range = pos_ext < CMPW'(CELL_COUNT);
  assign pos_addr     = pos_ext[AW-1:0];
  assign pos_clamped  = pos_in_range ? pos_addr : AW'(CELL_COUNT - 1);

  assign row_last = (row == RW'(ROWS - 1));
  assign col_last = (col == CLW'(COLUMNS - 1));

  // Store write port: pending copy first, then sweeps, then the single
  // cell write of a character or backspace transaction.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = fill_cell;
    priority if (copy_pending) begin
      mem_we    = 1'b1;
      mem_waddr = copy_dst;
      mem_wdata = mem_rdata;
    end else if (state == S_FILL) begin
      mem_we = 1'b1;
    end else if (accept && action == ACT_WRITE && char_code != NEWLINE_CODE) begin
      mem_we    = 1'b1;
      mem_waddr = cur_addr;
      mem_wdata = {attribute, char_code};
    end else if (accept && action == ACT_BACK) begin
      mem_we    = 1'b1;
      mem_waddr = bs_addr;
      mem_wdata = {attribute, SPACE_CODE};
    end else begin
      mem_we = 1'b0;
    end
  end

  // Scroll reads walk the source rows; otherwise the read port serves a read.
  assign mem_raddr = (state == S_SCROLL) ? ptr : pos_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_FILL;
      ptr          <= '0;
      fill_cell    <= {RESET_ATTR, SPACE_CODE};
      fill_report  <= 1'b0;
      row          <= '0;
      col          <= '0;
      done         <= 1'b0;
      copy_pending <= 1'b0;
      cell_word    <= '0;
    end else begin
      done         <= 1'b0;
      copy_pending <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cell_word <= '0;
            unique case (action)
              ACT_WRITE: begin
                if (char_code == NEWLINE_CODE || col_last) begin
                  col <= '0;
                  if (row_last) begin
                    // next line past the bottom: scroll the screen up
                    state     <= S_SCROLL;
                    ptr       <= AW'(COLUMNS);
                    fill_cell <= {attribute, SPACE_CODE};
                  end else begin
                    row  <= row + RW'(1);
                    done <= 1'b1;
                  end
                end else begin
                  col  <= col + CLW'(1);
                  done <= 1'b1;
                end
              end
              ACT_BACK: begin
                if (col != '0) begin
                  col <= col - CLW'(1);
                end else if (row != '0) begin
                  row <= row - RW'(1);
                  col <= CLW'(COLUMNS - 1);
                end
                done <= 1'b1;
              end
              ACT_SET: begin
                state <= S_SPLIT;
              end
              ACT_CLEAR: begin
                row         <= '0;
                col         <= '0;
                fill_cell   <= {attribute, SPACE_CODE};
                ptr         <= '0;
                fill_report <= 1'b1;
                state       <= S_FILL;
              end
              ACT_READ: begin
                if (pos_in_range) begin
                  state <= S_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          cell_word <= mem_rdata;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        S_SPLIT: begin
          if (split_done) begin
            row   <= split_row;
            col   <= split_col;
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_SCROLL: begin
          // read cell ptr now, write it one row up next cycle
          copy_pending <= 1'b1;
          copy_dst     <= ptr - AW'(COLUMNS);
          if (ptr == AW'(CELL_COUNT - 1)) begin
            state <= S_FLUSH;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        S_FLUSH: begin
          // last copy lands this cycle; then blank the bottom row
          ptr         <= AW'(CELL_COUNT - COLUMNS);
          fill_report <= 1'b1;
          state       <= S_FILL;
        end
        S_FILL: begin
          if (ptr == AW'(CELL_COUNT - 1)) begin
            state <= S_IDLE;
            done  <= fill_report;
          end else begin
            ptr <= ptr + AW'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  tccw_screen_mem #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  tccw_pos_split #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS),
    .AW      (AW),
    .RW      (RW),
    .CLW     (CLW)
  ) u_split (
    .clk   (clk),
    .rst   (rst),
    .go    (split_go),
    .value (pos_clamped),
    .done  (split_done),
    .row   (split_row),
    .col   (split_col)
  );

  // Reset always starts the clearing pass.
  a_reset_busy: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low after reset");

  // A copy write only follows a scroll read.
  a_copy_phase: assert property (@(posedge clk) disable iff (rst)
    copy_pending |-> (state == S_SCROLL || state == S_FLUSH))
    else $error("copy write outside scroll");

  // Reported cursor always lies on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ({1'b0, cur_addr} < (AW + 1)'(CELL_COUNT)))
    else $error("cursor off screen");

  // A clear never completes in the next cycle.
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (accept && action == ACT_CLEAR) |=> (busy && !done))
    else $error("clear finished without sweep");

endmodule

`default_nettype wire

@@ bench/console_screen_checker.sv @@
// Checker for the text console cell writer: screen predictor and in-order result compare.
module console_screen_checker
  import tccw_pkg::*;
#(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  logic [ACTION_W-1:0] action,
  input  logic [CHAR_W-1:0]   char_code,
  input  logic [ATTR_W-1:0]   attribute,
  input  logic [POS_W-1:0]    position,
  input  logic                done,
  input  logic [POS_W-1:0]    cursor_index,
  input  logic [CELL_W-1:0]   cell_word,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CELL_COUNT = COLUMNS * ROWS;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [POS_W-1:0]    cursor;
    logic [CELL_W-1:0]   word;
  } screen_result_t;

  logic [CELL_W-1:0] screen_mirror [CELL_COUNT];
  int unsigned       cur_row;
  int unsigned       cur_col;
  screen_result_t    expected_q [$];
  int                mismatches = 0;
  int                queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  function automatic logic [CELL_W-1:0] blank_of(input logic [ATTR_W-1:0] attr);
    return {attr, SPACE_CODE};
  endfunction

  function automatic void fill_screen(input logic [CELL_W-1:0] glyph);
    for (int i = 0; i < CELL_COUNT; i++) screen_mirror[i] = glyph;
  endfunction

  // Column home, next row; below the last row the screen moves up one row.
  function automatic void line_feed(input logic [ATTR_W-1:0] attr);
    cur_col = 0;
    cur_row++;
    if (cur_row >= ROWS) begin
      for (int i = 0; i + COLUMNS < CELL_COUNT; i++) screen_mirror[i] = screen_mirror[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_mirror[i] = blank_of(attr);
      cur_row = ROWS - 1;
    end
  endfunction

  function automatic int unsigned cursor_slot();
    int unsigned idx;
    idx = cur_row * COLUMNS + cur_col;
    return (idx < CELL_COUNT) ? idx : CELL_COUNT - 1;
  endfunction

  function automatic screen_result_t apply_command(input logic [ACTION_W-1:0] act,
                                                   input logic [CHAR_W-1:0]   code,
                                                   input logic [ATTR_W-1:0]   attr,
                                                   input logic [POS_W-1:0]    pos);
    screen_result_t res;
    int unsigned    target;
    res.action = act;
    res.word   = '0;
    case (act)
      ACT_WRITE: begin
        if (code == NEWLINE_CODE) begin
          line_feed(attr);
        end else begin
          screen_mirror[cursor_slot()] = {attr, code};
          cur_col++;
          if (cur_col >= COLUMNS) line_feed(attr);
        end
      end
      ACT_BACK: begin
        if (cur_col > 0) begin
          cur_col--;
        end else if (cur_row > 0) begin
          cur_row--;
          cur_col = COLUMNS - 1;
        end
        screen_mirror[cursor_slot()] = blank_of(attr);
      end
      ACT_SET: begin
        target  = (pos >= CELL_COUNT) ? CELL_COUNT - 1 : pos;
        cur_row = target / COLUMNS;
        cur_col = target % COLUMNS;
      end
      ACT_CLEAR: begin
        fill_screen(blank_of(attr));
        cur_row = 0;
        cur_col = 0;
      end
      ACT_READ: begin
        if (pos < CELL_COUNT) res.word = screen_mirror[pos];
      end
      default: ;
    endcase
    res.cursor = POS_W'(cur_row * COLUMNS + cur_col);
    return res;
  endfunction

  // Results compare before the push: a result never belongs to the
  // transaction accepted at the same edge.
  always @(posedge clk) begin
    screen_result_t want;
    if (rst) begin
      fill_screen({RESET_ATTR, SPACE_CODE});
      cur_row = 0;
      cur_col = 0;
      expected_q.delete();
    end else begin
      if (done === 1'b1) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing pending: expected none, actual cursor %0d word %h",
                   $time, cursor_index, cell_word);
        end else begin
          want = expected_q.pop_front();
          if (cursor_index !== want.cursor) begin
            mismatches++;
            $display("%0t: action %0d cursor_index: expected %0d, actual %0d",
                     $time, want.action, want.cursor, cursor_index);
          end
          if (cell_word !== want.word) begin
            mismatches++;
            $display("%0t: action %0d cell_word: expected %h, actual %h",
                     $time, want.action, want.word, cell_word);
          end
        end
      end
      if (start && busy === 1'b0)
        expected_q.push_back(apply_command(action, char_code, attribute, position));
    end
    queued = expected_q.size();
  end

endmodule

@@ bench/text_console_cell_writer_test.sv @@
// Testbench top for the text console cell writer: stimulus, watchdog and verdict.
module text_console_cell_writer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int CELL_COUNT     = DEF_COLUMNS * DEF_ROWS;
  localparam int LAST_ROW_START = CELL_COUNT - DEF_COLUMNS;
  localparam int POS_MAX        = 2 ** POS_W - 1;
  localparam int BYTE_MAX       = 2 ** CHAR_W - 1;
  localparam int ITEM_TARGET    = 650;
  localparam int DRAIN_EVERY    = 160;
  // A scroll or clear walks the whole store; the reset clearing pass is
  // as long. Several times that with no transaction is a hang.
  localparam int QUIET_LIMIT    = 20000;
  localparam int TAIL_CYCLES    = 16;

  // Action codes past the defined set; the block must leave state alone.
  localparam logic [ACTION_W-1:0] ACT_UNDEF_FIRST = ACT_READ + 1'b1;
  localparam logic [ACTION_W-1:0] ACT_UNDEF_LAST  = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [ACTION_W-1:0] action = '0;
  logic [CHAR_W-1:0]   char_code = '0;
  logic [ATTR_W-1:0]   attribute = '0;
  logic [POS_W-1:0]    position = '0;
  logic                busy;
  logic                done;
  logic [POS_W-1:0]    cursor_index;
  logic [CELL_W-1:0]   cell_word;
  int                  fail_count;
  int                  pending;

  int item_count   = 0;  // defined actions only; undefined codes don't count
  int burst_left   = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  text_console_cell_writer #(
    .COLUMNS (DEF_COLUMNS),
    .ROWS    (DEF_ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .char_code    (char_code),
    .attribute    (attribute),
    .position     (position),
    .done         (done),
    .cursor_index (cursor_index),
    .cell_word    (cell_word)
  );

  console_screen_checker #(
    .COLUMNS (DEF_COLUMNS),
    .ROWS    (DEF_ROWS)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .char_code    (char_code),
    .attribute    (attribute),
    .position     (position),
    .done         (done),
    .cursor_index (cursor_index),
    .cell_word    (cell_word),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // Watchdog: any accepted transaction or result restarts the count.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || done === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [CHAR_W-1:0] rnd_byte();
    return CHAR_W'($urandom_range(0, BYTE_MAX));
  endfunction

  // Mostly printable-or-not bytes, with newline forced now and then.
  function automatic logic [CHAR_W-1:0] rnd_char();
    if ($urandom_range(0, 11) == 0) return NEWLINE_CODE;
    return rnd_byte();
  endfunction

  // Positions lean toward the bottom row and past the end of the store.
  function automatic logic [POS_W-1:0] rnd_pos();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return POS_W'($urandom_range(CELL_COUNT, POS_MAX));
    if (r < 3) return POS_W'($urandom_range(LAST_ROW_START, CELL_COUNT - 1));
    return POS_W'($urandom_range(0, CELL_COUNT - 1));
  endfunction

  // Start held low while the fields carry junk, which must be ignored; n sets how long.
  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start     <= 1'b0;
      action    <= ACTION_W'($urandom_range(0, ACT_UNDEF_LAST));
      char_code <= rnd_byte();
      attribute <= rnd_byte();
      position  <= POS_W'($urandom_range(0, POS_MAX));
    end
  endtask

  // Hold off until the checker has seen every result that is owed.
  task automatic drain();
    pause(1);
    while (pending != 0) @(negedge clk);
  endtask

  // One transaction: present at the falling edge, hold until a rising edge
  // sees busy low. Start stays high into the next transaction of a burst.
  task automatic send_cmd(input logic [ACTION_W-1:0] act,
                          input logic [CHAR_W-1:0]   code,
                          input logic [ATTR_W-1:0]   attr,
                          input logic [POS_W-1:0]    pos);
    @(negedge clk);
    start     <= 1'b1;
    action    <= act;
    char_code <= code;
    attribute <= attr;
    position  <= pos;
    do @(posedge clk); while (busy !== 1'b0);
    if (act <= ACT_READ) item_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pause($urandom_range(1, 8));
      // Now and then a long burst with no gaps at all.
      burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 14);
    end
  endtask

  initial begin
    int                 pick;
    int                 run_len;
    int                 next_drain;
    logic [POS_W-1:0]   base;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Reset contents: home, last cell, first index past the end, top of range.
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), '0);
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(CELL_COUNT - 1));
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(CELL_COUNT));
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(POS_MAX));
    // Field extremes at home.
    send_cmd(ACT_WRITE, '1, '1, rnd_pos());
    send_cmd(ACT_WRITE, '0, '0, rnd_pos());
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(1));
    // Backspace mid-line, down to home, then at home.
    send_cmd(ACT_BACK, rnd_byte(), 8'h5A, rnd_pos());
    send_cmd(ACT_BACK, rnd_byte(), 8'hC3, rnd_pos());
    send_cmd(ACT_BACK, rnd_byte(), 8'h81, rnd_pos());
    // Wrap at line end, then backspace over the line start.
    send_cmd(ACT_SET, rnd_byte(), rnd_byte(), POS_W'(DEF_COLUMNS - 1));
    send_cmd(ACT_WRITE, 8'h41, 8'h1F, rnd_pos());
    send_cmd(ACT_BACK, rnd_byte(), 8'h2E, rnd_pos());
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(DEF_COLUMNS - 1));
    // Clamp to the last cell, then wrap past the last row: scroll.
    send_cmd(ACT_SET, rnd_byte(), rnd_byte(), POS_W'(POS_MAX));
    send_cmd(ACT_WRITE, 8'h7E, 8'h4B, rnd_pos());
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(LAST_ROW_START - 1));
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(LAST_ROW_START));
    // Newline on the last row scrolls; newline mid-screen does not.
    send_cmd(ACT_WRITE, NEWLINE_CODE, 8'h6C, rnd_pos());
    send_cmd(ACT_SET, rnd_byte(), rnd_byte(), POS_W'(100));
    send_cmd(ACT_WRITE, NEWLINE_CODE, 8'h33, rnd_pos());
    // Undefined actions.
    send_cmd(ACT_UNDEF_FIRST, rnd_byte(), rnd_byte(), rnd_pos());
    send_cmd(ACT_UNDEF_FIRST + 1'b1, rnd_byte(), rnd_byte(), rnd_pos());
    send_cmd(ACT_UNDEF_LAST, rnd_byte(), rnd_byte(), rnd_pos());
    // Clear, then look at home.
    send_cmd(ACT_CLEAR, rnd_byte(), '1, rnd_pos());
    send_cmd(ACT_READ, rnd_byte(), rnd_byte(), '0);
    drain();

    // ---- random part ----
    next_drain = item_count + DRAIN_EVERY;
    while (item_count < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // Typing run with stray backspaces, then read back around its start.
        base = rnd_pos();
        if ($urandom_range(0, 1) == 1) send_cmd(ACT_SET, rnd_byte(), rnd_byte(), base);
        run_len = $urandom_range(1, 24);
        for (int k = 0; k < run_len; k++) begin
          if ($urandom_range(0, 9) == 0) send_cmd(ACT_BACK, rnd_byte(), rnd_byte(), rnd_pos());
          else send_cmd(ACT_WRITE, rnd_char(), rnd_byte(), rnd_pos());
        end
        repeat ($urandom_range(1, 4))
          send_cmd(ACT_READ, rnd_byte(), rnd_byte(), POS_W'(base + $urandom_range(0, run_len)));
      end else if (pick < 65) begin
        repeat ($urandom_range(1, 8)) send_cmd(ACT_READ, rnd_byte(), rnd_byte(), rnd_pos());
      end else if (pick < 77) begin
        repeat ($urandom_range(1, 10)) send_cmd(ACT_BACK, rnd_byte(), rnd_byte(), rnd_pos());
      end else if (pick < 85) begin
        send_cmd(ACT_SET, rnd_byte(), rnd_byte(), POS_W'($urandom_range(0, POS_MAX)));
      end else if (pick < 88) begin
        send_cmd(ACT_CLEAR, rnd_byte(), rnd_byte(), rnd_pos());
      end else if (pick < 95) begin
        // Bottom row: newlines and wraps scroll; kept short since each
        // scroll walks the whole store.
        send_cmd(ACT_SET, rnd_byte(), rnd_byte(),
                 POS_W'($urandom_range(LAST_ROW_START, CELL_COUNT - 1)));
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 2) == 0) send_cmd(ACT_WRITE, NEWLINE_CODE, rnd_byte(), rnd_pos());
          else send_cmd(ACT_WRITE, rnd_byte(), rnd_byte(), rnd_pos());
        end
        repeat (2)
          send_cmd(ACT_READ, rnd_byte(), rnd_byte(),
                   POS_W'($urandom_range(LAST_ROW_START - DEF_COLUMNS, CELL_COUNT - 1)));
      end else begin
        send_cmd(ACTION_W'($urandom_range(ACT_UNDEF_FIRST, ACT_UNDEF_LAST)),
                 rnd_byte(), rnd_byte(), rnd_pos());
      end
      if (item_count >= next_drain) begin
        drain();
        next_drain = item_count + DRAIN_EVERY;
      end
    end

    // ---- wind down ----
    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/tccw_pkg.sv
hdl/tccw_screen_mem.sv
hdl/tccw_pos_split.sv
hdl/text_console_cell_writer.sv
bench/console_screen_checker.sv
bench/text_console_cell_writer_test.sv
